[rtl/mspcd_pkg.sv]
// Shared types, codes and coil tables for the stepper phase-chain driver.
`default_nettype none

package mspcd_pkg;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_HOME = 2'd2;

  localparam logic [1:0] REG_MOTOR_COUNT     = 2'd0;
  localparam logic [1:0] REG_DRIVE_MODE      = 2'd1;
  localparam logic [1:0] REG_LINES_PER_MOTOR = 2'd2;
  localparam logic [1:0] REG_HAS_CLEAR_LINE  = 2'd3;

  localparam int ADDR_W = 4;

  localparam logic [3:0] WAVE_TABLE [4] = '{4'hE, 4'hD, 4'hB, 4'h7};
  localparam logic [3:0] HALF_TABLE [8] = '{4'hE, 4'hC, 4'hD, 4'h9,
                                            4'hB, 4'h3, 4'h7, 4'h6};

  typedef struct packed {
    logic [4:0] motor_count;
    logic       drive_mode;
    logic [3:0] lines_per_motor;
    logic       has_clear_line;
  } cfg_t;

  typedef struct packed {
    logic        load;
    logic        home;
    logic        tick;
    logic        active;
    logic        shift;
    logic        drive_mode;
    logic [15:0] steps;
  } cell_ctrl_t;

  typedef struct packed {
    logic       mv;
    logic [7:0] pat;
  } frame_t;

  // Inverted coil drive for a phase; upper bits come out high.
  function automatic logic [7:0] coil_pattern(input logic mode, input logic [2:0] phase);
    logic [3:0] cmd;
    cmd = mode ? HALF_TABLE[phase] : WAVE_TABLE[phase[1:0]];
    return ~{4'b0000, cmd};
  endfunction

endpackage

`default_nettype wire

[rtl/mspcd_regs.sv]
// APB configuration registers of the stepper phase-chain driver.
`default_nettype none

module mspcd_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mspcd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output mspcd_pkg::cfg_t                  cfg
);
  import mspcd_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.motor_count     <= 5'd16;
      cfg.drive_mode      <= 1'b0;
      cfg.lines_per_motor <= 4'd4;
      cfg.has_clear_line  <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MOTOR_COUNT:     cfg.motor_count     <= pwdata[4:0];
        REG_DRIVE_MODE:      cfg.drive_mode      <= pwdata[0];
        REG_LINES_PER_MOTOR: cfg.lines_per_motor <= pwdata[3:0];
        REG_HAS_CLEAR_LINE:  cfg.has_clear_line  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MOTOR_COUNT:     prdata = {27'd0, cfg.motor_count};
      REG_DRIVE_MODE:      prdata = {31'd0, cfg.drive_mode};
      REG_LINES_PER_MOTOR: prdata = {28'd0, cfg.lines_per_motor};
      REG_HAS_CLEAR_LINE:  prdata = {31'd0, cfg.has_clear_line};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/mspcd_cell.sv]
// One motor cell: position, pending steps and one stage of the frame shift chain.
`default_nettype none

module mspcd_cell (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire mspcd_pkg::cell_ctrl_t  ctrl,
  input  wire mspcd_pkg::frame_t      frame_in,
  output mspcd_pkg::frame_t           frame_out
);
  import mspcd_pkg::*;

  logic [31:0]        pos;
  logic [15:0]        pend;
  frame_t             frame;

  logic               moving;
  logic [31:0]        pos_step;
  logic [15:0]        pend_step;
  logic signed [32:0] neg_pos;
  logic [15:0]        home_pend;

  always_comb begin
    moving    = ctrl.tick && ctrl.active && (pend != 16'd0);
    pos_step  = pend[15] ? pos - 32'd1 : pos + 32'd1;
    pend_step = pend[15] ? pend + 16'd1 : pend - 16'd1;
    neg_pos   = 33'sd0 - $signed({pos[31], pos});
    if (neg_pos > 33'sd32767) begin
      home_pend = 16'h7FFF;
    end else if (neg_pos < -33'sd32768) begin
      home_pend = 16'h8000;
    end else begin
      home_pend = neg_pos[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= 32'd0;
      pend <= 16'd0;
    end else if (ctrl.load && ctrl.active) begin
      pend <= ctrl.steps;
    end else if (ctrl.home && ctrl.active) begin
      pend <= home_pend;
    end else if (moving) begin
      pos  <= pos_step;
      pend <= pend_step;
    end
  end

  // Frame stage: loaded on a tick from the post-step position, then shifted upward.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame.mv <= 1'b0;
    end else if (ctrl.tick) begin
      frame.mv  <= moving;
      frame.pat <= coil_pattern(ctrl.drive_mode, moving ? pos_step[2:0] : pos[2:0]);
    end else if (ctrl.shift) begin
      frame <= frame_in;
    end
  end

  assign frame_out = frame;

endmodule

`default_nettype wire

[rtl/multi_stepper_phase_chain_driver.sv]
// Top level of the stepper phase-chain driver: request decode, cell chain and frame sequencer.
//
// One cell per motor holds its position and pending steps. A load or home request is taken
// without raising busy. A tick steps every active cell with pending steps at once, loads each
// cell's coil pattern into a shift chain and then walks the chain from the top cell down, one
// cell per cycle outside the padding: without a clear line, n - h padding results (h highest
// moved motor, n active motors) come before the first pattern; busy is high until the walk
// ends. From the first result on, results leave one per cycle on result_strobe, registered, in
// the cycle after they are formed; the receiver cannot hold them off and each one is present
// for a single cycle. A tick that moves nothing walks the chain and emits nothing.
`default_nettype none

module multi_stepper_phase_chain_driver #(
  parameter int MOTORS       = 16,
  parameter int PATTERN_BITS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mspcd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   req_type,
  input  wire logic [3:0]                   motor,
  input  wire logic signed [15:0]           steps,
  output logic                              result_strobe,
  output logic [7:0]                        coil_bits,
  output logic [3:0]                        motor_slot,
  output logic                              is_padding,
  output logic                              latch
);
  import mspcd_pkg::*;

  localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int CNT_W = $clog2(MOTORS + 1);
  localparam logic [7:0] PAT_MASK = 8'((1 << PATTERN_BITS) - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PAD  = 2'd2;

  cfg_t             cfg;
  cell_ctrl_t       ctrl [MOTORS];
  frame_t           chain [MOTORS+1];

  logic [1:0]       state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] pad_cnt, pad_cnt_next;
  logic             started, started_next;
  logic [CNT_W-1:0] n_act;
  logic             accept;
  logic             do_load, do_home, do_tick;
  logic             shift;
  logic             emit, emit_pad;
  frame_t           top;

  mspcd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign do_load = accept && (req_type == REQ_LOAD);
  assign do_home = accept && (req_type == REQ_HOME);
  assign do_tick = accept && (req_type == REQ_TICK);
  assign n_act   = (32'(cfg.motor_count) > MOTORS) ? CNT_W'(MOTORS) : CNT_W'(cfg.motor_count);

  assign chain[0] = '0;
  assign top      = chain[MOTORS];

  for (genvar i = 0; i < MOTORS; i++) begin : g_cell
    always_comb begin
      ctrl[i].load       = do_load && (32'(motor) == 32'(i));
      ctrl[i].home       = do_home;
      ctrl[i].tick       = do_tick;
      ctrl[i].active     = 32'(cfg.motor_count) > 32'(i);
      ctrl[i].shift      = shift;
      ctrl[i].drive_mode = cfg.drive_mode;
      ctrl[i].steps      = steps;
    end

    mspcd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl[i]),
      .frame_in  (chain[i]),
      .frame_out (chain[i+1])
    );
  end

  // During the walk the top of the chain shows motor idx; cells above the highest mover are skipped.
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    pad_cnt_next = pad_cnt;
    started_next = started;
    shift        = 1'b0;
    emit         = 1'b0;
    emit_pad     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (do_tick) begin
          state_next   = S_SCAN;
          idx_next     = IDX_W'(MOTORS - 1);
          started_next = 1'b0;
        end
      end
      S_SCAN: begin
        if (!started && top.mv && !cfg.has_clear_line) begin
          state_next   = S_PAD;
          started_next = 1'b1;
          pad_cnt_next = n_act - CNT_W'(idx);
        end else begin
          emit  = started || top.mv;
          shift = 1'b1;
          if (top.mv) begin
            started_next = 1'b1;
          end
          if (idx == '0) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx - IDX_W'(1);
          end
        end
      end
      S_PAD: begin
        emit_pad     = 1'b1;
        pad_cnt_next = pad_cnt - CNT_W'(1);
        if (pad_cnt == CNT_W'(1)) begin
          state_next = S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      started       <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      started       <= started_next;
      result_strobe <= emit || emit_pad;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    pad_cnt <= pad_cnt_next;
    if (emit_pad) begin
      coil_bits  <= 8'd0;
      motor_slot <= 4'd0;
      is_padding <= 1'b1;
      latch      <= 1'b0;
    end else if (emit) begin
      coil_bits  <= top.pat & PAT_MASK;
      motor_slot <= 4'(idx);
      is_padding <= 1'b0;
      latch      <= (idx == '0);
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the stepper phase-chain driver: request stream, register phases, frame checks.
`timescale 1ns / 1ps

module tb_top;
  import mspcd_pkg::*;

  localparam int MOTORS       = 16;
  localparam int DRAIN_CYCLES = 2 * MOTORS + 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Coil tables, not yet inverted
  localparam logic [3:0] WAVE_CMD [4] = '{4'b1110, 4'b1101, 4'b1011, 4'b0111};
  localparam logic [3:0] HALF_CMD [8] = '{4'b1110, 4'b1100, 4'b1101, 4'b1001,
                                          4'b1011, 4'b0011, 4'b0111, 4'b0110};

  typedef struct packed {
    logic [1:0]         req;
    logic [3:0]         motor;
    logic signed [15:0] steps;
  } request_t;

  typedef struct packed {
    logic [7:0] coil;
    logic [3:0] slot;
    logic       pad;
    logic       last;
  } chain_pat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         req_type = REQ_LOAD;
  logic [3:0]         motor = '0;
  logic signed [15:0] steps = '0;
  logic               result_strobe;
  logic [7:0]         coil_bits;
  logic [3:0]         motor_slot;
  logic               is_padding;
  logic               latch;

  multi_stepper_phase_chain_driver dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .req_type(req_type), .motor(motor), .steps(steps),
    .result_strobe(result_strobe), .coil_bits(coil_bits), .motor_slot(motor_slot),
    .is_padding(is_padding), .latch(latch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow state of the motor row
  logic [31:0] shadow_pos [MOTORS];
  logic [15:0] shadow_pending [MOTORS];
  logic [4:0]  cfg_motor_count = 5'd16;
  logic        cfg_drive_mode = 1'b0;
  logic [3:0]  cfg_lines = 4'd4;
  logic        cfg_clear_line = 1'b1;

  request_t   request_queue [$];
  chain_pat_t pattern_queue [$];
  request_t   cur_request;
  bit         holding;
  int         sender_idle_pct = 0;

  int errors = 0;
  int requests_done = 0;
  int patterns_checked = 0;
  int frames_seen = 0;
  int settings_run = 0;
  int cycle_count = 0;

  initial begin
    for (int i = 0; i < MOTORS; i++) begin
      shadow_pos[i] = '0;
      shadow_pending[i] = '0;
    end
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("MISMATCH: %s", msg);
  endtask

  function automatic logic [7:0] coil_for(input logic [31:0] pos);
    logic [3:0] cmd;
    cmd = cfg_drive_mode ? HALF_CMD[pos[2:0]] : WAVE_CMD[pos[1:0]];
    return ~{4'b0000, cmd};
  endfunction

  // Applies one request to the shadow row and queues the frame it produces.
  function automatic void step_motors(input request_t rq);
    int n;
    int high;
    bit moved;
    longint p;
    longint v;
    chain_pat_t e;
    n = (cfg_motor_count < MOTORS) ? int'(cfg_motor_count) : MOTORS;
    high = 0;
    moved = 1'b0;
    case (rq.req)
      REQ_LOAD: begin
        if (int'(rq.motor) < n) shadow_pending[rq.motor] = rq.steps;
      end
      REQ_HOME: begin
        for (int i = 0; i < n; i++) begin
          p = longint'($signed(shadow_pos[i]));
          v = -p;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          shadow_pending[i] = v[15:0];
        end
      end
      REQ_TICK: begin
        for (int i = 0; i < n; i++) begin
          if (shadow_pending[i] != 16'd0) begin
            if (shadow_pending[i][15]) begin
              shadow_pending[i] = shadow_pending[i] + 16'd1;
              shadow_pos[i] = shadow_pos[i] - 32'd1;
            end else begin
              shadow_pending[i] = shadow_pending[i] - 16'd1;
              shadow_pos[i] = shadow_pos[i] + 32'd1;
            end
            moved = 1'b1;
            high = i;
          end
        end
        if (moved) begin
          if (!cfg_clear_line) begin
            for (int i = 0; i < n - high; i++) begin
              e = '{coil: 8'd0, slot: 4'd0, pad: 1'b1, last: 1'b0};
              pattern_queue.push_back(e);
            end
          end
          for (int s = high; s >= 0; s--) begin
            e = '{coil: coil_for(shadow_pos[s]), slot: 4'(s), pad: 1'b0, last: (s == 0)};
            pattern_queue.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] reg_value(input logic [1:0] idx);
    case (idx)
      REG_MOTOR_COUNT:     return {27'd0, cfg_motor_count};
      REG_DRIVE_MODE:      return {31'd0, cfg_drive_mode};
      REG_LINES_PER_MOTOR: return {28'd0, cfg_lines};
      default:             return {31'd0, cfg_clear_line};
    endcase
  endfunction

  // Driver: holds a request until the transfer, then picks the next one or idles.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      holding = start;
      if (start && !busy) begin
        step_motors(cur_request);
        requests_done++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          cur_request = request_queue.pop_front();
          req_type <= cur_request.req;
          motor <= cur_request.motor;
          steps <= cur_request.steps;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed pattern against the oldest expected one
  always @(posedge clk) begin
    chain_pat_t got;
    chain_pat_t want;
    if (!rst && result_strobe) begin
      got = '{coil: coil_bits, slot: motor_slot, pad: is_padding, last: latch};
      if (pattern_queue.size() == 0) begin
        flag_error($sformatf("unexpected pattern coil=%02h slot=%0d pad=%b latch=%b",
                             coil_bits, motor_slot, is_padding, latch));
      end else begin
        want = pattern_queue.pop_front();
        patterns_checked++;
        if (want.last) frames_seen++;
        if (got !== want) begin
          flag_error($sformatf("exp coil=%02h slot=%0d pad=%b latch=%b, got coil=%02h slot=%0d pad=%b latch=%b",
                               want.coil, want.slot, want.pad, want.last,
                               got.coil, got.slot, got.pad, got.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multi_stepper_phase_chain_driver verification failed");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MOTOR_COUNT:     cfg_motor_count = val[4:0];
      REG_DRIVE_MODE:      cfg_drive_mode = val[0];
      REG_LINES_PER_MOTOR: cfg_lines = val[3:0];
      default:             cfg_clear_line = val[0];
    endcase
  endtask

  task automatic reg_check(input logic [1:0] idx);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_value(idx))
      flag_error($sformatf("register %0d read %08h, exp %08h", idx, prdata, reg_value(idx)));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until every request is through and the chain walk has wound down.
  task automatic settle();
    while (request_queue.size() != 0 || start || pattern_queue.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_request(input logic [1:0] req, input logic [3:0] m,
                             input logic signed [15:0] st);
    request_t rq;
    rq = '{req: req, motor: m, steps: st};
    request_queue.push_back(rq);
  endtask

  // Mostly ticks and loads of short moves; a few long moves, homes and junk codes.
  function automatic request_t random_request();
    request_t rq;
    int r;
    int sel;
    r = $urandom_range(99);
    rq.motor = 4'($urandom_range(15));
    rq.steps = 16'($urandom);
    if (r < 32) begin
      rq.req = REQ_LOAD;
      sel = $urandom_range(19);
      if (sel < 16) rq.steps = 16'(int'($urandom_range(30)) - 15);
      else if (sel < 19) rq.steps = 16'(int'($urandom_range(600)) - 300);
    end else if (r < 90) begin
      rq.req = REQ_TICK;
    end else if (r < 96) begin
      rq.req = REQ_HOME;
    end else begin
      rq.req = REQ_UNUSED;
    end
    return rq;
  endfunction

  task automatic run_setting(input logic [4:0] count, input logic mode, input logic [3:0] lines,
                             input logic clear_line, input int idle_pct, input int n_req);
    settle();
    // junk in the unused upper bits must be dropped
    reg_write(REG_MOTOR_COUNT, {$urandom} << 5 | 32'(count));
    reg_write(REG_DRIVE_MODE, {$urandom} << 1 | 32'(mode));
    reg_write(REG_LINES_PER_MOTOR, {$urandom} << 4 | 32'(lines));
    reg_write(REG_HAS_CLEAR_LINE, {$urandom} << 1 | 32'(clear_line));
    reg_check(REG_MOTOR_COUNT);
    reg_check(REG_DRIVE_MODE);
    reg_check(REG_LINES_PER_MOTOR);
    reg_check(REG_HAS_CLEAR_LINE);
    settings_run++;
    sender_idle_pct = idle_pct;
    for (int i = 0; i < n_req; i++) request_queue.push_back(random_request());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset values, then directed requests under them
    reg_check(REG_MOTOR_COUNT);
    reg_check(REG_DRIVE_MODE);
    reg_check(REG_LINES_PER_MOTOR);
    reg_check(REG_HAS_CLEAR_LINE);
    settings_run++;
    add_request(REQ_TICK, 4'd0, 16'sd0);        // nothing pending: no frame
    add_request(REQ_LOAD, 4'd0, 16'sd2);
    add_request(REQ_LOAD, 4'd15, -16'sd3);
    add_request(REQ_TICK, 4'd0, 16'sd0);
    add_request(REQ_TICK, 4'd0, 16'sd0);
    add_request(REQ_TICK, 4'd0, 16'sd0);
    add_request(REQ_LOAD, 4'd5, 16'sh7FFF);
    add_request(REQ_TICK, 4'd0, 16'sd0);
    add_request(REQ_LOAD, 4'd5, 16'sh8000);
    add_request(REQ_TICK, 4'd0, 16'sd0);
    add_request(REQ_TICK, 4'd0, 16'sd0);
    add_request(REQ_LOAD, 4'd5, 16'sd0);
    add_request(REQ_HOME, 4'd10, 16'sd100);
    add_request(REQ_TICK, 4'd0, 16'sd0);
    add_request(REQ_TICK, 4'd0, 16'sd0);
    add_request(REQ_TICK, 4'd0, 16'sd0);
    add_request(REQ_UNUSED, 4'd15, -16'sd1);
    add_request(REQ_TICK, 4'd15, -16'sd1);
    add_request(REQ_LOAD, 4'd3, -16'sd1);
    add_request(REQ_LOAD, 4'd10, 16'sd5);
    add_request(REQ_TICK, 4'd0, 16'sd0);
    add_request(REQ_HOME, 4'd0, 16'sd0);
    add_request(REQ_TICK, 4'd0, 16'sd0);
    add_request(REQ_TICK, 4'd0, 16'sd0);

    run_setting(5'd16, 1'b1, 4'd8, 1'b0, 0, 60);
    run_setting(5'd1, 1'b0, 4'd1, 1'b0, 53, 60);
    run_setting(5'd9, 1'b1, 4'd15, 1'b1, 0, 60);
    run_setting(5'd31, 1'b0, 4'd0, 1'b0, 20, 60);
    run_setting(5'd0, 1'b1, 4'd4, 1'b0, 53, 15);   // no active motor
    run_setting(5'd16, 1'b0, 4'd4, 1'b1, 20, 45);
    settle();

    $display("Ran %0d requests under %0d register settings, idle gaps 0/20/53 percent.",
             requests_done, settings_run);
    $display("Checked %0d chain patterns in %0d latched frames, %0d mismatches.",
             patterns_checked, frames_seen, errors);
    if (errors == 0) begin
      $display("multi_stepper_phase_chain_driver verification clean");
    end else begin
      $display("multi_stepper_phase_chain_driver verification failed");
    end
    $finish;
  end

endmodule
